// ----- rtl/brtt_pkg.sv -----
// ----------------------------------------------------------------------------
// brtt_pkg
// shared types and constants of the byte run trend tracker
// ----------------------------------------------------------------------------
package brtt_pkg;

  localparam int ENTRY_W    = 11;
  localparam int SAMPLE_W   = 8;
  localparam int RUN_W      = 16;
  localparam int MAG_W      = 15;
  localparam int AGE_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRESH_WINDOW = 3'd3;

  localparam logic [7:0]       RECORD_MIN_RST   = 8'd3;
  localparam logic [MAG_W-1:0] MIN_RUN_RST      = 15'd3;
  localparam logic [MAG_W-1:0] MAX_RUN_RST      = 15'd120;
  localparam logic [7:0]       FRESH_WINDOW_RST = 8'd4;

  localparam logic signed [RUN_W-1:0] RUN_CEIL  = 16'sd32000;
  localparam logic signed [RUN_W-1:0] RUN_FLOOR = -16'sd32000;
  localparam logic [AGE_W-1:0]        AGE_MAX   = 8'd255;

  typedef struct packed {
    logic [ENTRY_W-1:0]  entry;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]       entry_out;
    logic signed [RUN_W-1:0]  run_now;
    logic                     pick_valid;
    logic signed [RUN_W-1:0]  pick_run;
    logic [SAMPLE_W-1:0]      pick_value;
  } out_t;

  // per-entry state word
  typedef struct packed {
    logic                     seen;
    logic [SAMPLE_W-1:0]      last_value;
    logic signed [RUN_W-1:0]  run_length;
    logic signed [RUN_W-1:0]  saved_run;
    logic [SAMPLE_W-1:0]      saved_value;
    logic [AGE_W-1:0]         saved_age;
  } state_t;

  localparam state_t STATE_RESET = '{
    seen: 1'b0, last_value: '0, run_length: '0,
    saved_run: '0, saved_value: '0, saved_age: AGE_MAX
  };

  // state store write port
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    state_t             data;
  } wr_t;

  // item between update and select stages
  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               oob;
    state_t             st;
  } mid_t;

endpackage

// ----- rtl/brtt_store.sv -----
// ----------------------------------------------------------------------------
// brtt_store
// per-entry state memory with write-to-read bypass and clear sweep after reset
// ----------------------------------------------------------------------------
module brtt_store #(
  parameter int ENTRIES = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [brtt_pkg::ENTRY_W-1:0]  rd_addr,
  input  brtt_pkg::wr_t                 wr,
  output brtt_pkg::state_t              rd_data,
  output logic                          clearing
);
  import brtt_pkg::*;

  localparam int DEPTH = (ENTRIES < 2048) ? ENTRIES : 2048;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t          mem [DEPTH];
  state_t          rd_data_r;
  logic            clr_r;
  logic [AW-1:0]   clr_cnt_r;

  // clear sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= STATE_RESET;
    end else if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      // same-edge write wins over the array
      if (wr.en && !clr_r && wr.addr == rd_addr) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// ----- rtl/brtt_update.sv -----
// ----------------------------------------------------------------------------
// brtt_update
// read stage and run update stage, writes the new state word back
// ----------------------------------------------------------------------------
module brtt_update #(
  parameter int ENTRIES = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  brtt_pkg::in_t     in_item,
  input  brtt_pkg::state_t  rd_word,
  input  logic [7:0]        record_min,
  input  logic              nxt_ready,
  output logic              a_ready,
  output brtt_pkg::wr_t     wr,
  output logic              b_valid,
  output brtt_pkg::mid_t    b_item
);
  import brtt_pkg::*;

  logic                 a_v_r;
  logic [ENTRY_W-1:0]   a_entry_r;
  logic [SAMPLE_W-1:0]  a_sample_r;
  logic                 a_oob_r;
  logic                 b_v_r;
  mid_t                 b_r;
  logic                 b_ready;
  logic                 a_fire;
  logic                 up;
  logic                 down;
  logic                 cont;
  logic [RUN_W-1:0]     run_mag;
  state_t               st;
  state_t               nw;

  assign b_ready = !b_v_r || nxt_ready;
  assign a_ready = !a_v_r || b_ready;
  assign a_fire  = a_v_r && b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_fire;
      if (b_ready) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_entry_r  <= in_item.entry;
      a_sample_r <= in_item.sample;
      a_oob_r    <= (32'(in_item.entry) >= ENTRIES);
    end
    if (a_fire) begin
      b_r.entry <= a_entry_r;
      b_r.oob   <= a_oob_r;
      b_r.st    <= nw;
    end
  end

  always_comb begin
    st      = rd_word;
    up      = ({1'b0, a_sample_r} == ({1'b0, st.last_value} + 9'd1));
    down    = ({1'b0, st.last_value} == ({1'b0, a_sample_r} + 9'd1));
    run_mag = st.run_length[RUN_W-1] ? RUN_W'(-st.run_length) : RUN_W'(st.run_length);
    cont    = (up && !st.run_length[RUN_W-1]) ||
              (down && (st.run_length[RUN_W-1] || st.run_length == '0));
    nw = st;
    if (!st.seen) begin
      // first sample only primes the entry
      nw.seen       = 1'b1;
      nw.last_value = a_sample_r;
    end else begin
      if (st.saved_age != AGE_MAX) nw.saved_age = st.saved_age + 8'd1;
      if (cont) begin
        if (up) begin
          nw.run_length = (st.run_length == RUN_CEIL) ? RUN_CEIL : st.run_length + 16'sd1;
        end else begin
          nw.run_length = (st.run_length == RUN_FLOOR) ? RUN_FLOOR : st.run_length - 16'sd1;
        end
      end else begin
        if (run_mag >= {8'b0, record_min}) begin
          nw.saved_run   = st.run_length;
          nw.saved_value = st.last_value;
          nw.saved_age   = '0;
        end
        nw.run_length = '0;
      end
      nw.last_value = a_sample_r;
    end
  end

  always_comb begin
    wr.en   = a_fire && !a_oob_r;
    wr.addr = a_entry_r;
    wr.data = nw;
  end

  assign b_valid = b_v_r;
  assign b_item  = b_r;

endmodule

// ----- rtl/brtt_select.sv -----
// ----------------------------------------------------------------------------
// brtt_select
// candidate choice stage and bounds check / output stage
// ----------------------------------------------------------------------------
module brtt_select (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         b_valid,
  input  brtt_pkg::mid_t               b_item,
  input  logic [brtt_pkg::MAG_W-1:0]   min_run,
  input  logic [brtt_pkg::MAG_W-1:0]   max_run,
  input  logic [7:0]                   fresh_window,
  input  logic                         out_stall,
  output logic                         b_ready,
  output logic                         out_valid,
  output brtt_pkg::out_t               out_data
);
  import brtt_pkg::*;

  logic                     c_v_r;
  logic [ENTRY_W-1:0]       c_entry_r;
  logic                     c_oob_r;
  logic signed [RUN_W-1:0]  c_run_now_r;
  logic signed [RUN_W-1:0]  c_pick_r;
  logic [SAMPLE_W-1:0]      c_pval_r;
  logic [MAG_W-1:0]         c_mag_r;
  logic                     o_v_r;
  out_t                     o_r;
  logic                     c_ready;
  logic                     o_ready;
  logic [RUN_W-1:0]         mag_s;
  logic [RUN_W-1:0]         mag_r;
  logic                     pick_saved;
  logic                     in_bounds;

  assign o_ready = !o_v_r || !out_stall;
  assign c_ready = !c_v_r || o_ready;
  assign b_ready = c_ready;

  always_comb begin
    mag_s = b_item.st.saved_run[RUN_W-1] ? RUN_W'(-b_item.st.saved_run)
                                         : RUN_W'(b_item.st.saved_run);
    mag_r = b_item.st.run_length[RUN_W-1] ? RUN_W'(-b_item.st.run_length)
                                          : RUN_W'(b_item.st.run_length);
    pick_saved = (b_item.st.saved_age <= fresh_window) && (mag_s > mag_r);
  end

  assign in_bounds = (c_mag_r >= min_run) && (c_mag_r <= max_run);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (c_ready) c_v_r <= b_valid;
      if (o_ready) o_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_entry_r   <= b_item.entry;
      c_oob_r     <= b_item.oob;
      c_run_now_r <= b_item.st.run_length;
      c_pick_r    <= pick_saved ? b_item.st.saved_run : b_item.st.run_length;
      c_pval_r    <= pick_saved ? b_item.st.saved_value : b_item.st.last_value;
      c_mag_r     <= pick_saved ? mag_s[MAG_W-1:0] : mag_r[MAG_W-1:0];
    end
    if (o_ready && c_v_r) begin
      o_r.entry_out <= c_entry_r;
      if (c_oob_r) begin
        o_r.run_now    <= '0;
        o_r.pick_valid <= 1'b0;
        o_r.pick_run   <= '0;
        o_r.pick_value <= '0;
      end else begin
        o_r.run_now    <= c_run_now_r;
        o_r.pick_valid <= in_bounds;
        o_r.pick_run   <= c_pick_r;
        o_r.pick_value <= c_pval_r;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

// ----- rtl/byte_run_trend_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// byte_run_trend_tracker_unit
// per-entry +1/-1 run tracker with saved-run candidate selection
// ----------------------------------------------------------------------------
// Takes one transfer per clock (entry index and its new byte) and returns one
// result transfer per input, in order, through the read, update, choice and
// output registers. Sustained rate, without output stalls, is one item per
// cycle, set by the single read-modify-write pass over the per-entry state
// memory, where a write-to-read bypass lets back-to-back samples of the same
// entry see each other's update. After reset the state memory is swept to its
// reset contents, one entry a cycle; in_stall stays high until min(ENTRIES,
// 2048) entries (2048 by default) are cleared. Configuration writes are taken
// during the sweep. Configuration should only change while no item is in
// flight. Entries at or above ENTRIES return their index and zero fields.
// ----------------------------------------------------------------------------
module byte_run_trend_tracker_unit #(
  parameter int ENTRIES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  brtt_pkg::in_t                   in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output brtt_pkg::out_t                  out_data,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [brtt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [brtt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import brtt_pkg::*;

  // configuration registers
  logic [7:0]       record_min_r;
  logic [MAG_W-1:0] min_run_r;
  logic [MAG_W-1:0] max_run_r;
  logic [7:0]       fresh_window_r;

  logic             clearing;
  logic             a_ready;
  logic             in_fire;
  logic             b_valid;
  logic             b_ready;
  state_t           rd_word;
  wr_t              wr;
  mid_t             b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_min_r   <= RECORD_MIN_RST;
      min_run_r      <= MIN_RUN_RST;
      max_run_r      <= MAX_RUN_RST;
      fresh_window_r <= FRESH_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RECORD_MIN:   record_min_r   <= cfg_wdata[7:0];
        REG_MIN_RUN:      min_run_r      <= cfg_wdata[MAG_W-1:0];
        REG_MAX_RUN:      max_run_r      <= cfg_wdata[MAG_W-1:0];
        REG_FRESH_WINDOW: fresh_window_r <= cfg_wdata[7:0];
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // no input transfer while the sweep runs or the read stage is blocked
  assign in_stall = clearing || !a_ready;
  assign in_fire  = in_valid && !in_stall;

  // state memory, read issued with the input transfer
  brtt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (in_data.entry),
    .wr       (wr),
    .rd_data  (rd_word),
    .clearing (clearing)
  );

  // run update and write-back
  brtt_update #(
    .ENTRIES (ENTRIES)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_item    (in_data),
    .rd_word    (rd_word),
    .record_min (record_min_r),
    .nxt_ready  (b_ready),
    .a_ready    (a_ready),
    .wr         (wr),
    .b_valid    (b_valid),
    .b_item     (b_item)
  );

  // candidate choice and output register
  brtt_select u_select (
    .clk          (clk),
    .rst_n        (rst_n),
    .b_valid      (b_valid),
    .b_item       (b_item),
    .min_run      (min_run_r),
    .max_run      (max_run_r),
    .fresh_window (fresh_window_r),
    .out_stall    (out_stall),
    .b_ready      (b_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

// ----- rtl/brtt_port_checker.sv -----
// ----------------------------------------------------------------------------
// brtt_port_checker
// port-level checks of the run trend tracker, bound to the top level
// ----------------------------------------------------------------------------
module brtt_port_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input brtt_pkg::out_t  out_data
);
  import brtt_pkg::*;

  logic [RUN_W-1:0] mag_now;
  logic [RUN_W-1:0] mag_pick;

  assign mag_now  = out_data.run_now[RUN_W-1] ? RUN_W'(-out_data.run_now)
                                              : RUN_W'(out_data.run_now);
  assign mag_pick = out_data.pick_run[RUN_W-1] ? RUN_W'(-out_data.pick_run)
                                               : RUN_W'(out_data.pick_run);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the clear sweep blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clear sweep");

  // the candidate is never shorter than the current run
  a_pick_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mag_pick >= mag_now)
    else $error("candidate shorter than current run");

  // runs stay inside the clamp
  a_run_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_now <= RUN_CEIL) && (out_data.run_now >= RUN_FLOOR))
    else $error("run outside clamp");

endmodule

bind byte_run_trend_tracker_unit brtt_port_checker u_port_checker (.*);

// ----- verif/brtt_result_checker.sv -----
// ----------------------------------------------------------------------------
// brtt_result_checker
// watches both channels of the run trend tracker, predicts each result from
// its own copy of the per-entry state and compares results in order
// ----------------------------------------------------------------------------
module brtt_result_checker #(
  parameter int ENTRIES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  brtt_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  brtt_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [brtt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [brtt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     fail_count,
  output int unsigned                     results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import brtt_pkg::*;

  // per-entry trend state
  logic        ent_seen   [ENTRIES];
  logic [7:0]  ent_last   [ENTRIES];
  int          ent_run    [ENTRIES];
  int          kept_run   [ENTRIES];
  logic [7:0]  kept_value [ENTRIES];
  logic [7:0]  kept_age   [ENTRIES];

  int unsigned rec_min;
  int unsigned min_len;
  int unsigned max_len;
  int unsigned fresh_win;

  out_t        trend_results_q [$];
  int unsigned mism_total = 0;

  function automatic int unsigned run_mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_t track_sample(in_t item);
    out_t        res;
    int          e;
    int          delta;
    int          cur;
    int          nxt;
    int          chosen;
    logic [7:0]  chosen_val;
    int unsigned len;
    res = '0;
    res.entry_out = item.entry;
    e = int'(item.entry);
    if (e >= ENTRIES) return res;
    if (!ent_seen[e]) begin
      ent_seen[e] = 1'b1;
      ent_last[e] = item.sample;
    end else begin
      delta = int'(item.sample) - int'(ent_last[e]);
      cur   = ent_run[e];
      if (kept_age[e] != AGE_MAX) kept_age[e] = kept_age[e] + 8'd1;
      if ((delta == 1 && cur >= 0) || (delta == -1 && cur <= 0)) begin
        nxt = cur + delta;
        if (nxt > int'(RUN_CEIL)) nxt = int'(RUN_CEIL);
        if (nxt < int'(RUN_FLOOR)) nxt = int'(RUN_FLOOR);
        ent_run[e] = nxt;
      end else begin
        // broken run, kept only when long enough
        if (run_mag(cur) >= rec_min) begin
          kept_run[e]   = cur;
          kept_value[e] = ent_last[e];
          kept_age[e]   = '0;
        end
        ent_run[e] = 0;
      end
      ent_last[e] = item.sample;
    end
    chosen     = ent_run[e];
    chosen_val = ent_last[e];
    if (kept_age[e] <= fresh_win && run_mag(kept_run[e]) > run_mag(chosen)) begin
      chosen     = kept_run[e];
      chosen_val = kept_value[e];
    end
    len = run_mag(chosen);
    res.run_now    = RUN_W'(ent_run[e]);
    res.pick_valid = (len >= min_len && len <= max_len);
    res.pick_run   = RUN_W'(chosen);
    res.pick_value = chosen_val;
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    logic bad;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ent_seen[i]   = 1'b0;
        ent_last[i]   = '0;
        ent_run[i]    = 0;
        kept_run[i]   = 0;
        kept_value[i] = '0;
        kept_age[i]   = AGE_MAX;
      end
      rec_min   = RECORD_MIN_RST;
      min_len   = MIN_RUN_RST;
      max_len   = MAX_RUN_RST;
      fresh_win = FRESH_WINDOW_RST;
      trend_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RECORD_MIN:   rec_min   = cfg_wdata[7:0];
          REG_MIN_RUN:      min_len   = cfg_wdata[MAG_W-1:0];
          REG_MAX_RUN:      max_len   = cfg_wdata[MAG_W-1:0];
          REG_FRESH_WINDOW: fresh_win = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (trend_results_q.size() == 0) begin
          mism_total++;
          if (mism_total <= 10)
            $display("%0t: result transfer with none pending: entry %0d run %0d",
                     $realtime, out_data.entry_out, out_data.run_now);
        end else begin
          want = trend_results_q.pop_front();
          bad  = (out_data.entry_out  !== want.entry_out)  ||
                 (out_data.run_now    !== want.run_now)    ||
                 (out_data.pick_valid !== want.pick_valid) ||
                 (out_data.pick_run   !== want.pick_run)   ||
                 (out_data.pick_value !== want.pick_value);
          if (bad) begin
            mism_total++;
            if (mism_total <= 10)
              $display({"%0t: mismatch exp entry %0d run %0d ok %0b pick %0d val %0d",
                        " / got entry %0d run %0d ok %0b pick %0d val %0d"},
                       $realtime, want.entry_out, want.run_now, want.pick_valid,
                       want.pick_run, want.pick_value, out_data.entry_out,
                       out_data.run_now, out_data.pick_valid, out_data.pick_run,
                       out_data.pick_value);
          end
        end
      end
      if (in_valid && !in_stall) trend_results_q.push_back(track_sample(in_data));
    end
    fail_count   <= mism_total;
    results_owed <= trend_results_q.size();
  end

endmodule

// ----- verif/tb_byte_run_trend_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// tb_byte_run_trend_tracker_unit
// stimulus and verdict for the byte run trend tracker
// ----------------------------------------------------------------------------
// Drives directed samples, then phases of random run sequences under several
// register settings, with random gaps on both sides and one long result
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_byte_run_trend_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import brtt_pkg::*;

  localparam int          ENTRIES          = 2048;
  localparam int          DRAIN_CYCLES     = 16;   // margin past the pipeline latency
  localparam int          HOLD_OFF_CYCLES  = 300;
  localparam int          RANDOM_PER_PHASE = 170;
  localparam int          NUM_PHASES       = 6;
  localparam int          POOL_SIZE        = 8;
  localparam int unsigned LIMIT_NS         = 2_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned           fail_count;
  int unsigned           results_owed;

  // idle odds in percent, and the hold-off request count
  int                    tx_idle_pct = 30;
  int                    rx_idle_pct = 30;
  int                    hold_off_ask = 0;
  int                    hold_off_taken = 0;

  // what the sender last put on each entry, used to build runs
  logic [7:0]            sent_last [ENTRIES];
  logic                  sent_up   [ENTRIES];
  logic [ENTRY_W-1:0]    pool      [POOL_SIZE];

  byte_run_trend_tracker_unit #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  brtt_result_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop for a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("byte_run_trend_tracker_unit verification failed");
    $finish;
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_ask != hold_off_taken) begin
        hold_off_taken = hold_off_ask;
        out_stall <= 1'b1;
        // counted here so the sender keeps pushing until the block backs up
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // one input transfer, with a random gap in front of it
  task automatic send_sample(input logic [ENTRY_W-1:0] e, input logic [7:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{entry: e, sample: s};
    sent_last[e] = s;
    // payload holds until the block takes it
    do @(posedge clk); while (in_stall);
  endtask

  // block drained: all results back, then DRAIN_CYCLES of margin
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all four registers, junk above the 8-bit ones, then a write to a
  // nonexistent index that must be ignored
  task automatic program_regs(input logic [7:0] rm, input logic [MAG_W-1:0] mn,
                              input logic [MAG_W-1:0] mx, input logic [7:0] fw);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RECORD_MIN;
    cfg_wdata <= {(CFG_DATA_W-8)'($urandom), rm};
    @(posedge clk);
    cfg_idx   <= REG_MIN_RUN;
    cfg_wdata <= mn;
    @(posedge clk);
    cfg_idx   <= REG_MAX_RUN;
    cfg_wdata <= mx;
    @(posedge clk);
    cfg_idx   <= REG_FRESH_WINDOW;
    cfg_wdata <= {(CFG_DATA_W-8)'($urandom), fw};
    @(posedge clk);
    cfg_idx   <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                           int'(REG_FRESH_WINDOW) + 1));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly +1/-1 runs on a small pool of entries, plus jumps, flat samples
  // and stray entries anywhere in the index range
  task automatic random_traffic(input int n);
    int                 sent;
    int                 r;
    int                 k;
    logic [ENTRY_W-1:0] e;
    logic [7:0]         s;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      e = pool[$urandom_range(POOL_SIZE-1)];
      if (r < 70) begin
        k = $urandom_range(6, 1);
        repeat (k) begin
          // occasional turn around breaks the run
          if ($urandom_range(11) == 0) sent_up[e] = !sent_up[e];
          if (sent_up[e] && sent_last[e] == 8'hFF) sent_up[e] = 1'b0;
          else if (!sent_up[e] && sent_last[e] == 8'h00) sent_up[e] = 1'b1;
          s = sent_up[e] ? sent_last[e] + 8'd1 : sent_last[e] - 8'd1;
          send_sample(e, s);
          sent++;
        end
      end else if (r < 85) begin
        send_sample(e, 8'($urandom));
        sent++;
      end else if (r < 95) begin
        send_sample(ENTRY_W'($urandom), 8'($urandom));
        sent++;
      end else begin
        // flat step, a break with zero delta
        send_sample(e, sent_last[e]);
        sent++;
      end
    end
  endtask

  initial begin
    int                 phase;
    int                 i;
    logic [ENTRY_W-1:0] e;

    for (i = 0; i < ENTRIES; i++) begin
      sent_last[i] = '0;
      sent_up[i]   = 1'b1;
    end

    // synchronous reset at the start
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values written back explicitly
    program_regs(RECORD_MIN_RST, MIN_RUN_RST, MAX_RUN_RST, FRESH_WINDOW_RST);

    // directed: rising run of 4, kept on a break and picked while fresh
    for (i = 10; i <= 14; i++) send_sample(ENTRY_W'(0), 8'(i));
    send_sample(ENTRY_W'(0), 8'd20);
    send_sample(ENTRY_W'(0), 8'd21);
    // top entry, falling run too short to keep
    send_sample('1, 8'hFF);
    send_sample('1, 8'hFE);
    send_sample('1, 8'hFD);
    send_sample('1, 8'hFF);
    // flat sample is a break
    send_sample(ENTRY_W'(5), 8'h00);
    send_sample(ENTRY_W'(5), 8'h00);
    // byte extremes: full-scale jumps both ways
    send_sample(ENTRY_W'(1024), 8'h00);
    send_sample(ENTRY_W'(1024), 8'hFF);
    send_sample(ENTRY_W'(1024), 8'h00);
    // falling run of 3 kept, then a short rising run loses to it
    for (i = 9; i >= 6; i--) send_sample(ENTRY_W'(7), 8'(i));
    send_sample(ENTRY_W'(7), 8'd50);
    send_sample(ENTRY_W'(7), 8'd51);
    wait_idle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (i = 0; i < POOL_SIZE; i++) pool[i] = ENTRY_W'($urandom);
      case (phase)
        0: program_regs(RECORD_MIN_RST, MIN_RUN_RST, MAX_RUN_RST, FRESH_WINDOW_RST);
        // every break kept, zero runs too; every nonzero run in bounds; stale still fresh
        1: program_regs(8'd0, 15'd1, 15'd32000, 8'd255);
        // only runs of 255 or more kept, only runs of 32000 valid, only brand-new kept runs count
        2: program_regs(8'd255, 15'd32000, 15'd32000, 8'd0);
        // empty bounds window
        3: program_regs(8'd2, 15'd200, 15'd10, 8'd8);
        4: program_regs(8'd1, 15'd0, 15'h7FFF, 8'd255);
        default: program_regs(8'($urandom_range(6)), 15'($urandom_range(12, 1)),
                              15'($urandom_range(255, 4)), 8'($urandom_range(12)));
      endcase

      if (phase == 0) begin
        // back-to-back on both sides; results held off long enough to fill
        // the block and push back on the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_ask++;
      end

      if (phase == 4) begin
        // full ramp to a run of 255, kept on the break, then the age
        // counter runs into saturation while the kept run is still picked
        e = ENTRY_W'($urandom);
        for (i = 0; i < 256; i++) send_sample(e, 8'(i));
        send_sample(e, 8'd100);
        repeat (260) send_sample(e, 8'd100);
        send_sample(e, 8'd101);
        send_sample(e, 8'd102);
      end

      random_traffic(RANDOM_PER_PHASE);
      wait_idle();
      tx_idle_pct = 30;
      rx_idle_pct = 30;
    end

    if (fail_count == 0) begin
      $display("byte_run_trend_tracker_unit verification clean");
    end else begin
      $display("byte_run_trend_tracker_unit verification failed");
    end
    $finish;
  end

endmodule
